@@ src/scci_pkg.sv @@
// Shared types and fixed widths for the segment / circle intersection unit.
// Used by every module under src; depends on nothing.
package scci_pkg;

  localparam int COORD_BITS          = 16;
  localparam int RATIO_FRACTION_BITS = 16;

  localparam int DIFF_W = COORD_BITS + 1;             // coordinate difference
  localparam int PROD_W = 2 * DIFF_W;                 // one signed product
  localparam int LEN_W  = PROD_W;                     // |E-S|^2, unsigned
  localparam int DOT_W  = PROD_W + 1;                 // (C-S).(E-S), signed
  localparam int RAD_W  = COORD_BITS - 1;             // radius
  localparam int RSQ_W  = 2 * RAD_W;                  // radius squared
  localparam int PROJ_W = RATIO_FRACTION_BITS + 1;    // clamped t
  localparam int PX_W   = DIFF_W + PROJ_W + 1;        // (E-S) * t, signed
  localparam int DIST_W = COORD_BITS + RATIO_FRACTION_BITS + 2; // scaled C-P
  localparam int SQ_W   = 2 * DIST_W - 2;             // one squared component
  localparam int SUM_W  = SQ_W + 1;                   // squared distance
  localparam int RR_W   = RSQ_W + 2 * RATIO_FRACTION_BITS; // scaled r^2

  localparam logic [PROJ_W-1:0] T_ONE = PROJ_W'(1) << RATIO_FRACTION_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] seg_start_x;
    logic signed [COORD_BITS-1:0] seg_start_y;
    logic signed [COORD_BITS-1:0] seg_end_x;
    logic signed [COORD_BITS-1:0] seg_end_y;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [RAD_W-1:0]      radius;
  } seg_query_t;

  typedef struct packed {
    logic              hit;
    logic [PROJ_W-1:0] projection;
    logic              degenerate;
  } seg_result_t;

  // Values that ride alongside the division ladder
  typedef struct packed {
    logic signed [DIFF_W-1:0] ac_x;
    logic signed [DIFF_W-1:0] ac_y;
    logic signed [DIFF_W-1:0] ab_x;
    logic signed [DIFF_W-1:0] ab_y;
    logic        [RSQ_W-1:0]  r2;
    logic                     degen;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic        [LEN_W-1:0] len2;
    logic signed [DOT_W-1:0] dot;
  } front_t;

  typedef struct packed {
    side_t             side;
    logic [PROJ_W-1:0] t;
  } divout_t;

endpackage

@@ src/scci_front.sv @@
// Front end: differences, products, and the length / dot sums (three stages).
// Depends on scci_pkg.
module scci_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  scci_pkg::seg_query_t q,
  output logic                out_vld,
  output scci_pkg::front_t    f
);
  import scci_pkg::*;

  // stage 1
  logic                     vld1;
  logic signed [DIFF_W-1:0] ab_x1, ab_y1, ac_x1, ac_y1;
  logic        [RAD_W-1:0]  r1;
  logic                     degen1;
  // stage 2
  logic                     vld2;
  logic signed [PROD_W-1:0] sq_x2, sq_y2, pd_x2, pd_y2;
  logic        [RSQ_W-1:0]  r2_2;
  logic signed [DIFF_W-1:0] ab_x2, ab_y2, ac_x2, ac_y2;
  logic                     degen2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      out_vld <= vld2;
    end
    if (en) begin
      ab_x1  <= DIFF_W'(q.seg_end_x) - DIFF_W'(q.seg_start_x);
      ab_y1  <= DIFF_W'(q.seg_end_y) - DIFF_W'(q.seg_start_y);
      ac_x1  <= DIFF_W'(q.center_x) - DIFF_W'(q.seg_start_x);
      ac_y1  <= DIFF_W'(q.center_y) - DIFF_W'(q.seg_start_y);
      r1     <= q.radius;
      degen1 <= (q.seg_end_x == q.seg_start_x) && (q.seg_end_y == q.seg_start_y);

      sq_x2  <= ab_x1 * ab_x1;
      sq_y2  <= ab_y1 * ab_y1;
      pd_x2  <= ac_x1 * ab_x1;
      pd_y2  <= ac_y1 * ab_y1;
      r2_2   <= r1 * r1;
      ab_x2  <= ab_x1;
      ab_y2  <= ab_y1;
      ac_x2  <= ac_x1;
      ac_y2  <= ac_y1;
      degen2 <= degen1;

      f.len2       <= LEN_W'($unsigned(sq_x2)) + LEN_W'($unsigned(sq_y2));
      f.dot        <= DOT_W'(pd_x2) + DOT_W'(pd_y2);
      f.side.ab_x  <= ab_x2;
      f.side.ab_y  <= ab_y2;
      f.side.ac_x  <= ac_x2;
      f.side.ac_y  <= ac_y2;
      f.side.r2    <= r2_2;
      f.side.degen <= degen2;
    end
  end

  a_degen_len: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (f.side.degen == (f.len2 == '0)))
    else $error("degenerate flag disagrees with zero segment length");

endmodule

@@ src/scci_divider.sv @@
// Clamp and restoring division ladder for t, one quotient bit per stage.
// Depends on scci_pkg.
module scci_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  scci_pkg::front_t  f,
  output logic              out_vld,
  output scci_pkg::divout_t d
);
  import scci_pkg::*;

  typedef enum logic [1:0] {T_ZERO, T_FULL, T_DIV} tmode_t;

  localparam int NSTEP = RATIO_FRACTION_BITS;

  logic                           vld_s  [0:NSTEP];
  tmode_t                         mode_s [0:NSTEP];
  side_t                          side_s [0:NSTEP];
  logic [LEN_W-1:0]               len_s  [0:NSTEP];
  logic [LEN_W-1:0]               rem_s  [0:NSTEP];
  logic [RATIO_FRACTION_BITS-1:0] q_s    [0:NSTEP];

  logic   dot_pos;
  tmode_t mode_in;

  assign dot_pos = !f.dot[DOT_W-1] && (f.dot != '0);

  always_comb begin
    if (f.side.degen || !dot_pos) begin
      mode_in = T_ZERO;
    end else if ($unsigned(f.dot) >= DOT_W'(f.len2)) begin
      mode_in = T_FULL;
    end else begin
      mode_in = T_DIV;
    end
  end

  // entry stage: classify
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s[0] <= 1'b0;
    end else if (en) begin
      vld_s[0] <= in_vld;
    end
    if (en) begin
      mode_s[0] <= mode_in;
      side_s[0] <= f.side;
      len_s[0]  <= f.len2;
      rem_s[0]  <= LEN_W'($unsigned(f.dot));
      q_s[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= NSTEP; k++) begin : g_step
    logic [LEN_W:0]   rem2;
    logic             ge;
    logic [LEN_W:0]   diff;

    assign rem2 = {rem_s[k-1], 1'b0};
    assign ge   = rem2 >= {1'b0, len_s[k-1]};
    assign diff = rem2 - {1'b0, len_s[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[k] <= 1'b0;
      end else if (en) begin
        vld_s[k] <= vld_s[k-1];
      end
      if (en) begin
        mode_s[k] <= mode_s[k-1];
        side_s[k] <= side_s[k-1];
        len_s[k]  <= len_s[k-1];
        rem_s[k]  <= ge ? diff[LEN_W-1:0] : rem2[LEN_W-1:0];
        q_s[k]    <= {q_s[k-1][RATIO_FRACTION_BITS-2:0], ge};
      end
    end
  end

  logic [PROJ_W-1:0] t_sel;

  always_comb begin
    case (mode_s[NSTEP])
      T_ZERO:  t_sel = '0;
      T_FULL:  t_sel = T_ONE;
      T_DIV:   t_sel = {1'b0, q_s[NSTEP]};
      default: t_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld_s[NSTEP];
    end
    if (en) begin
      d.t    <= t_sel;
      d.side <= side_s[NSTEP];
    end
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld_s[NSTEP] && (mode_s[NSTEP] == T_DIV) |-> rem_s[NSTEP] < len_s[NSTEP])
    else $error("division remainder not below divisor");

endmodule

@@ src/scci_dist.sv @@
// Closest point, squared distance and radius compare (four stages).
// Depends on scci_pkg.
module scci_dist (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_vld,
  input  scci_pkg::divout_t     d,
  output logic                  out_vld,
  output scci_pkg::seg_result_t res
);
  import scci_pkg::*;

  // stage 1: (E-S) * t
  logic                     vld1;
  logic signed [PX_W-1:0]   px1, py1;
  logic signed [DIFF_W-1:0] ac_x1, ac_y1;
  logic        [RSQ_W-1:0]  r2_1;
  logic        [PROJ_W-1:0] t1;
  logic                     degen1;
  // stage 2: scaled C-P
  logic                     vld2;
  logic signed [DIST_W-1:0] dx2, dy2;
  logic        [RSQ_W-1:0]  r2_2;
  logic        [PROJ_W-1:0] t2;
  logic                     degen2;
  // stage 3: squares
  logic                     vld3;
  logic        [SQ_W-1:0]   sqx3, sqy3;
  logic        [RR_W-1:0]   rr3;
  logic        [PROJ_W-1:0] t3;
  logic                     degen3;

  logic signed [PX_W-1:0]     t_s;
  logic signed [2*DIST_W-1:0] sqx_full, sqy_full;
  logic        [SUM_W-1:0]    dsum;

  assign t_s      = PX_W'($signed({1'b0, d.t}));
  assign sqx_full = (2*DIST_W)'(dx2) * (2*DIST_W)'(dx2);
  assign sqy_full = (2*DIST_W)'(dy2) * (2*DIST_W)'(dy2);
  assign dsum     = SUM_W'(sqx3) + SUM_W'(sqy3);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld1    <= in_vld;
      vld2    <= vld1;
      vld3    <= vld2;
      out_vld <= vld3;
    end
    if (en) begin
      px1    <= PX_W'(d.side.ab_x) * t_s;
      py1    <= PX_W'(d.side.ab_y) * t_s;
      ac_x1  <= d.side.ac_x;
      ac_y1  <= d.side.ac_y;
      r2_1   <= d.side.r2;
      t1     <= d.t;
      degen1 <= d.side.degen;

      dx2    <= (DIST_W'(ac_x1) <<< RATIO_FRACTION_BITS) - DIST_W'(px1);
      dy2    <= (DIST_W'(ac_y1) <<< RATIO_FRACTION_BITS) - DIST_W'(py1);
      r2_2   <= r2_1;
      t2     <= t1;
      degen2 <= degen1;

      sqx3   <= sqx_full[SQ_W-1:0];
      sqy3   <= sqy_full[SQ_W-1:0];
      rr3    <= {r2_2, {(2*RATIO_FRACTION_BITS){1'b0}}};
      t3     <= t2;
      degen3 <= degen2;

      res.hit        <= dsum <= SUM_W'(rr3);
      res.projection <= t3;
      res.degenerate <= degen3;
    end
  end

  a_degen_proj: assert property (@(posedge clk) disable iff (rst)
    out_vld && res.degenerate |-> res.projection == '0)
    else $error("degenerate segment with nonzero projection");

  a_proj_range: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> res.projection <= T_ONE)
    else $error("projection above 1.0");

endmodule

@@ src/segment_circle_intersect_unit.sv @@
// Segment / circle intersection unit. Takes one query per clock unless
// stalled (segment start, end and circle center in signed Q12.4, radius
// unsigned) and returns hit, the clamped projection t in Q1.16 (65536 = 1.0)
// and a degenerate flag. There are 3 front stages, 18 stages for the clamp
// and the 16-step restoring division of t, and 4 stages for the closest point
// and the radius compare. Throughput is one item per cycle; result_stall
// with result_valid high freezes the whole pipeline; query_stall follows it.
// Depends on scci_pkg, scci_front, scci_divider, scci_dist.
module segment_circle_intersect_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  query_valid,
  output logic                  query_stall,
  input  scci_pkg::seg_query_t  query,
  output logic                  result_valid,
  input  logic                  result_stall,
  output scci_pkg::seg_result_t result
);
  import scci_pkg::*;

  logic    adv;
  logic    front_vld, div_vld;
  front_t  front_out;
  divout_t div_out;

  // advance everything unless a finished beat is held at the output
  assign adv         = !result_valid || !result_stall;
  assign query_stall = !adv;

  scci_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (query_valid),
    .q       (query),
    .out_vld (front_vld),
    .f       (front_out)
  );

  scci_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (front_vld),
    .f       (front_out),
    .out_vld (div_vld),
    .d       (div_out)
  );

  scci_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_vld  (div_vld),
    .d       (div_out),
    .out_vld (result_valid),
    .res     (result)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    query_stall |-> result_valid && result_stall)
    else $error("input stalled without output backpressure");

endmodule
